FILE: hw/rtl/device_table_upsert_defines.svh
// Assertion macros shared by the device table RTL.
// Users must provide clk and rst_n in the scope where a macro is expanded.
`ifndef DEVICE_TABLE_UPSERT_DEFINES_SVH
`define DEVICE_TABLE_UPSERT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DTU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DTU_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/dtu_pkg.sv
// Shared types and constants for the device table.
// No dependencies; dtu_merge and device_table_upsert refer to this package.
package dtu_pkg;

  localparam int TABLE_ENTRIES = 32;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int CFG_W = 16;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam cnt_t FILL_MAX = cnt_t'(TABLE_ENTRIES);

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t REG_TX_DBM_UNKNOWN = 2'd0;
  localparam cfg_idx_t REG_FLAGS_NONE     = 2'd1;
  localparam cfg_idx_t REG_COMPANY_NONE   = 2'd2;

  typedef struct packed {
    logic [47:0]       key;
    logic signed [7:0] rssi;
    logic signed [7:0] tx_dbm;
    logic [7:0]        flags;
    logic [15:0]       company;
  } rec_t;

  typedef struct packed {
    logic signed [7:0] tx_dbm_unknown;
    logic [7:0]        flags_none;
    logic [15:0]       company_none;
  } sentinel_t;

  typedef struct packed {
    logic [4:0]  entry_index;
    logic        hit;
    logic        inserted;
    logic        dropped_full;
    logic [2:0]  record_changes;
    logic [15:0] batch_changes;
    logic [5:0]  entry_count;
    logic        batch_done;
  } result_t;

endpackage

FILE: hw/rtl/dtu_in_if.sv
// Input channel of the device table: one scan record or clear command per transaction.
// Standalone interface with valid/ready handshake; no dependencies.
interface dtu_in_if;
  logic              valid;
  logic              ready;
  logic              func;
  logic [47:0]       dev_addr;
  logic signed [7:0] rssi;
  logic signed [7:0] tx_dbm;
  logic [7:0]        adv_flags;
  logic [15:0]       mfr_id;
  logic              last_of_batch;

  modport source (
    output valid, func, dev_addr, rssi, tx_dbm, adv_flags, mfr_id, last_of_batch,
    input  ready
  );
  modport sink (
    input  valid, func, dev_addr, rssi, tx_dbm, adv_flags, mfr_id, last_of_batch,
    output ready
  );
endinterface

FILE: hw/rtl/dtu_out_if.sv
// Result channel of the device table: one result per transaction.
// Standalone interface with valid/ready handshake; no dependencies.
interface dtu_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  entry_index;
  logic        hit;
  logic        inserted;
  logic        dropped_full;
  logic [2:0]  record_changes;
  logic [15:0] batch_changes;
  logic [5:0]  entry_count;
  logic        batch_done;

  modport source (
    output valid, entry_index, hit, inserted, dropped_full, record_changes,
           batch_changes, entry_count, batch_done,
    input  ready
  );
  modport sink (
    input  valid, entry_index, hit, inserted, dropped_full, record_changes,
           batch_changes, entry_count, batch_done,
    output ready
  );
endinterface

FILE: hw/rtl/dtu_merge.sv
// Field merge for a matching table entry: applies sentinel rules and counts changes.
// Depends on dtu_pkg for the record and sentinel types.
module dtu_merge (
  input  dtu_pkg::rec_t      stored,
  input  dtu_pkg::rec_t      incoming,
  input  dtu_pkg::sentinel_t sent,
  output dtu_pkg::rec_t      merged,
  output logic [2:0]         changes
);

  always_comb begin
    merged  = stored;
    changes = 3'd0;
    if (stored.rssi != incoming.rssi) begin
      merged.rssi = incoming.rssi;
      changes     = changes + 3'd1;
    end
    if (incoming.tx_dbm != sent.tx_dbm_unknown && stored.tx_dbm != incoming.tx_dbm) begin
      merged.tx_dbm = incoming.tx_dbm;
      changes       = changes + 3'd1;
    end
    if (incoming.flags != sent.flags_none && stored.flags != incoming.flags) begin
      merged.flags = incoming.flags;
      changes      = changes + 3'd1;
    end
    if (incoming.company != sent.company_none && stored.company != incoming.company) begin
      merged.company = incoming.company;
      changes        = changes + 3'd1;
    end
  end

endmodule

FILE: hw/rtl/device_table_upsert.sv
// Device table: a merge walks the filled entries, one memory read per cycle; a hit in
// slot j ends the walk there, a miss walks all filled entries (up to all 32), and a
// clear skips the walk. One transaction is in flight; the next is accepted once a result
// is registered, and it finishes only once that result is taken.
// Synchronous active-low reset empties the table, zeroes the batch total, restores sentinels.
`include "device_table_upsert_defines.svh"

module device_table_upsert (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  dtu_pkg::cfg_idx_t           cfg_index,
  input  logic [dtu_pkg::CFG_W-1:0]   cfg_wdata,
  dtu_in_if.sink                      in_ch,
  dtu_out_if.source                   out_ch
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

  state_t               state_r;
  dtu_pkg::sentinel_t   sent_r;
  dtu_pkg::rec_t        item_r;
  logic                 func_r;
  logic                 last_r;
  dtu_pkg::cnt_t        ptr_r;
  logic                 pend_r;
  dtu_pkg::idx_t        pend_idx_r;
  logic                 hit_r;
  dtu_pkg::idx_t        idx_r;
  dtu_pkg::cnt_t        fill_r;
  logic [15:0]          batch_r;
  logic                 out_valid_r;
  dtu_pkg::result_t     out_r;

  dtu_pkg::rec_t        mem [dtu_pkg::TABLE_ENTRIES];
  dtu_pkg::rec_t        rdata_r;

  logic                 match;
  logic                 issue;
  dtu_pkg::idx_t        rd_addr;
  logic                 room;
  dtu_pkg::rec_t        merged;
  logic [2:0]           hit_chg;
  dtu_pkg::rec_t        wr_rec;
  dtu_pkg::idx_t        wr_idx;
  logic                 mem_we;
  logic [2:0]           chg;
  logic [16:0]          sum;
  logic [15:0]          total;
  logic                 done_go;
  dtu_pkg::cnt_t        fill_nxt;
  dtu_pkg::idx_t        res_idx;
  logic [dtu_pkg::IDX_W+4:0] idx_ext;
  logic [dtu_pkg::CNT_W+5:0] cnt_ext;
  dtu_pkg::result_t     res;
  logic [2:0]           out_kind;

  assign in_ch.ready = (state_r == S_IDLE);

  assign match   = pend_r && (rdata_r.key == item_r.key);
  assign rd_addr = ptr_r[dtu_pkg::IDX_W-1:0];
  assign issue   = (state_r == S_SCAN) && !match && (ptr_r < fill_r);
  assign room    = (fill_r < dtu_pkg::FILL_MAX);

  dtu_merge u_merge (
    .stored   (rdata_r),
    .incoming (item_r),
    .sent     (sent_r),
    .merged   (merged),
    .changes  (hit_chg)
  );

  always_comb begin
    wr_rec  = hit_r ? merged : item_r;
    wr_idx  = hit_r ? idx_r : fill_r[dtu_pkg::IDX_W-1:0];
    done_go = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);
    mem_we  = done_go && !func_r && (hit_r || room);

    if (func_r) begin
      chg = 3'd0;
    end else if (hit_r) begin
      chg = hit_chg;
    end else if (room) begin
      chg = 3'd1;
    end else begin
      chg = 3'd0;
    end

    sum   = {1'b0, batch_r} + 17'(chg);
    total = sum[16] ? 16'hFFFF : sum[15:0];

    if (func_r) begin
      fill_nxt = '0;
    end else if (!hit_r && room) begin
      fill_nxt = fill_r + 1'b1;
    end else begin
      fill_nxt = fill_r;
    end

    if (hit_r) begin
      res_idx = idx_r;
    end else if (room) begin
      res_idx = fill_r[dtu_pkg::IDX_W-1:0];
    end else begin
      res_idx = '0;
    end

    idx_ext = (dtu_pkg::IDX_W + 5)'(res_idx);
    cnt_ext = (dtu_pkg::CNT_W + 6)'(fill_nxt);

    res                = '0;
    if (!func_r) begin
      res.entry_index    = idx_ext[4:0];
      res.hit            = hit_r;
      res.inserted       = !hit_r && room;
      res.dropped_full   = !hit_r && !room;
      res.record_changes = chg;
      res.batch_changes  = total;
      res.entry_count    = cnt_ext[5:0];
      res.batch_done     = last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sent_r.tx_dbm_unknown <= 8'sd127;
      sent_r.flags_none     <= 8'd0;
      sent_r.company_none   <= 16'hFFFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dtu_pkg::REG_TX_DBM_UNKNOWN: sent_r.tx_dbm_unknown <= cfg_wdata[7:0];
        dtu_pkg::REG_FLAGS_NONE:     sent_r.flags_none     <= cfg_wdata[7:0];
        dtu_pkg::REG_COMPANY_NONE:   sent_r.company_none   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_idx] <= wr_rec;
    end
    if (issue) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      hit_r       <= 1'b0;
      fill_r      <= '0;
      batch_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            item_r.key     <= in_ch.dev_addr;
            item_r.rssi    <= in_ch.rssi;
            item_r.tx_dbm  <= in_ch.tx_dbm;
            item_r.flags   <= in_ch.adv_flags;
            item_r.company <= in_ch.mfr_id;
            func_r         <= in_ch.func;
            last_r         <= in_ch.last_of_batch;
            ptr_r          <= '0;
            pend_r         <= 1'b0;
            hit_r          <= 1'b0;
            state_r        <= in_ch.func ? S_DONE : S_SCAN;
          end
        end
        S_SCAN: begin
          if (match) begin
            hit_r   <= 1'b1;
            idx_r   <= pend_idx_r;
            pend_r  <= 1'b0;
            state_r <= S_DONE;
          end else if (issue) begin
            pend_r     <= 1'b1;
            pend_idx_r <= rd_addr;
            ptr_r      <= ptr_r + 1'b1;
          end else begin
            pend_r <= 1'b0;
            if (!pend_r) begin
              state_r <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (done_go) begin
            out_r       <= res;
            out_valid_r <= 1'b1;
            fill_r      <= fill_nxt;
            batch_r     <= (func_r || last_r) ? 16'd0 : total;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.entry_index    = out_r.entry_index;
  assign out_ch.hit            = out_r.hit;
  assign out_ch.inserted       = out_r.inserted;
  assign out_ch.dropped_full   = out_r.dropped_full;
  assign out_ch.record_changes = out_r.record_changes;
  assign out_ch.batch_changes  = out_r.batch_changes;
  assign out_ch.entry_count    = out_r.entry_count;
  assign out_ch.batch_done     = out_r.batch_done;

  assign out_kind = {out_r.hit, out_r.inserted, out_r.dropped_full};

  `DTU_ASSERT_IMP(a_fill_bound, 1'b1, fill_r <= dtu_pkg::FILL_MAX, "Fill over table size.")
  `DTU_ASSERT_IMP(a_scan_ptr, state_r == S_SCAN, ptr_r <= fill_r, "Scan pointer past fill.")
  `DTU_ASSERT_NXT(a_ins_fill, mem_we && !hit_r, fill_r == $past(fill_r) + 1'b1, "No growth.")
  `DTU_ASSERT_IMP(a_outcome, out_valid_r, $onehot0(out_kind), "Result has more than one outcome.")
  `DTU_ASSERT_IMP(a_ins_chg, out_valid_r && out_r.inserted, out_r.record_changes == 3'd1, "Ins.")

endmodule

FILE: tb/device_table_upsert_tb.sv
// Self-checking testbench for the device table upsert block.
// Drives scan records and clears through the dtu_in_if/dtu_out_if channels, checks every
// result against a table predictor or typed row; depends on dtu_pkg and RTL interfaces.
module device_table_upsert_tb;

  localparam logic              FUNC_MERGE    = 1'b0;
  localparam logic              FUNC_CLEAR    = 1'b1;
  localparam dtu_pkg::cfg_idx_t REG_UNUSED    = 2'd3;
  localparam int                RANDOM_PHASES = 12;
  localparam int                PHASE_ITEMS   = 150;
  localparam int                HOLD_CYCLES   = 400;
  localparam int                SETTLE_CYCLES = 40;
  localparam int                LIMIT_CYCLES  = 1500000;

  typedef struct packed {
    logic              func;
    logic [47:0]       addr;
    logic signed [7:0] rssi;
    logic signed [7:0] tx_dbm;
    logic [7:0]        flags;
    logic [15:0]       company;
    logic              last;
  } scan_item_t;

  typedef struct packed {
    scan_item_t       item;
    logic             typed;
    dtu_pkg::result_t res;
  } dir_row_t;

  localparam int DIR_ROWS = 14;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{'{FUNC_MERGE, 48'h0, 8'h80, 8'h80, 8'h00, 16'h0000, 1'b0}, 1'b1,
      '{5'd0, 1'b0, 1'b1, 1'b0, 3'd1, 16'd1, 6'd1, 1'b0}},
    '{'{FUNC_MERGE, 48'h0, 8'h80, 8'h7F, 8'h00, 16'hFFFF, 1'b0}, 1'b1,
      '{5'd0, 1'b1, 1'b0, 1'b0, 3'd0, 16'd1, 6'd1, 1'b0}},
    '{'{FUNC_MERGE, 48'h0, 8'h7F, 8'h7E, 8'hFF, 16'hFFFE, 1'b0}, 1'b1,
      '{5'd0, 1'b1, 1'b0, 1'b0, 3'd4, 16'd5, 6'd1, 1'b0}},
    '{'{FUNC_MERGE, 48'hFFFF_FFFF_FFFF, 8'h00, 8'h7F, 8'h00, 16'hFFFF, 1'b1}, 1'b1,
      '{5'd1, 1'b0, 1'b1, 1'b0, 3'd1, 16'd6, 6'd2, 1'b1}},
    '{'{FUNC_MERGE, 48'hFFFF_FFFF_FFFF, 8'h00, 8'h05, 8'h00, 16'hFFFF, 1'b0}, 1'b0, '0},
    '{'{FUNC_MERGE, 48'h0, 8'h7F, 8'h80, 8'h00, 16'h0000, 1'b0}, 1'b0, '0},
    '{'{FUNC_MERGE, 48'h1, 8'h01, 8'h01, 8'h01, 16'h0001, 1'b0}, 1'b0, '0},
    '{'{FUNC_MERGE, 48'h8000_0000_0000, 8'hFF, 8'hFF, 8'h80, 16'h8000, 1'b1}, 1'b0, '0},
    '{'{FUNC_CLEAR, 48'h1234_5678_9ABC, 8'h12, 8'h34, 8'h56, 16'h789A, 1'b1}, 1'b1, '0},
    '{'{FUNC_CLEAR, 48'h0, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0}, 1'b1, '0},
    '{'{FUNC_MERGE, 48'h5555_5555_5555, 8'h55, 8'h55, 8'h55, 16'h5555, 1'b1}, 1'b1,
      '{5'd0, 1'b0, 1'b1, 1'b0, 3'd1, 16'd1, 6'd1, 1'b1}},
    '{'{FUNC_MERGE, 48'hAAAA_AAAA_AAAA, 8'hAA, 8'hAA, 8'hAA, 16'hAAAA, 1'b0}, 1'b0, '0},
    '{'{FUNC_MERGE, 48'hAAAA_AAAA_AAAA, 8'hAA, 8'h2A, 8'hAA, 16'hAAAA, 1'b1}, 1'b0, '0},
    '{'{FUNC_MERGE, 48'h5555_5555_5555, 8'h55, 8'h7F, 8'h00, 16'hFFFF, 1'b1}, 1'b1,
      '{5'd0, 1'b1, 1'b0, 1'b0, 3'd0, 16'd0, 6'd2, 1'b1}}
  };

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  dtu_pkg::cfg_idx_t cfg_index;
  logic [15:0]       cfg_wdata;

  dtu_in_if  in_ch ();
  dtu_out_if out_ch ();

  device_table_upsert i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  dtu_pkg::rec_t      dev_table [dtu_pkg::TABLE_ENTRIES];
  int                 filled;
  int                 batch_sum;
  dtu_pkg::sentinel_t sentinels;
  dtu_pkg::result_t   pending_results [$];
  logic [47:0]        addr_pool [$];
  int                 errors = 0;
  int                 cycles = 0;
  bit                 steady = 1'b0;
  bit                 burst = 1'b0;
  bit                 hold_req = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 4) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [7:0] pick_byte(input logic [7:0] favored);
    case ($urandom_range(0, 5))
      0: return favored;
      1: begin
        case ($urandom_range(0, 3))
          0: return 8'h00;
          1: return 8'hFF;
          2: return 8'h7F;
          default: return 8'h80;
        endcase
      end
      2, 3: return 8'($urandom_range(0, 3));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_word(input logic [15:0] favored);
    case ($urandom_range(0, 5))
      0: return favored;
      1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      2, 3: return 16'($urandom_range(0, 3));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic scan_item_t random_item();
    scan_item_t it;
    it.func = ($urandom_range(0, 79) == 0) ? FUNC_CLEAR : FUNC_MERGE;
    if ($urandom_range(0, 9) == 0) it.addr = {16'($urandom), 32'($urandom)};
    else it.addr = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
    it.rssi = pick_byte(8'h00);
    it.tx_dbm = pick_byte(sentinels.tx_dbm_unknown);
    it.flags = pick_byte(sentinels.flags_none);
    it.company = pick_word(sentinels.company_none);
    it.last = ($urandom_range(0, 7) == 0);
    return it;
  endfunction

  function automatic dtu_pkg::result_t upsert_predict(input scan_item_t it);
    dtu_pkg::result_t r;
    int               slot;
    int               chg;
    int               total;
    bit               found;
    r = '0;
    slot = 0;
    chg = 0;
    found = 1'b0;
    if (it.func == FUNC_CLEAR) begin
      filled = 0;
      batch_sum = 0;
      return r;
    end
    for (int j = 0; j < filled; j++) begin
      if (!found && dev_table[j].key == it.addr) begin
        found = 1'b1;
        slot = j;
      end
    end
    if (found) begin
      r.hit = 1'b1;
      if (dev_table[slot].rssi != it.rssi) begin
        dev_table[slot].rssi = it.rssi;
        chg++;
      end
      if (it.tx_dbm != sentinels.tx_dbm_unknown && dev_table[slot].tx_dbm != it.tx_dbm) begin
        dev_table[slot].tx_dbm = it.tx_dbm;
        chg++;
      end
      if (it.flags != sentinels.flags_none && dev_table[slot].flags != it.flags) begin
        dev_table[slot].flags = it.flags;
        chg++;
      end
      if (it.company != sentinels.company_none && dev_table[slot].company != it.company) begin
        dev_table[slot].company = it.company;
        chg++;
      end
    end else if (filled < dtu_pkg::TABLE_ENTRIES) begin
      slot = filled;
      dev_table[slot] = '{it.addr, it.rssi, it.tx_dbm, it.flags, it.company};
      filled++;
      r.inserted = 1'b1;
      chg = 1;
    end else begin
      r.dropped_full = 1'b1;
    end
    total = batch_sum + chg;
    if (total > 65535) total = 65535;
    batch_sum = it.last ? 0 : total;
    r.entry_index = dtu_pkg::idx_t'(slot);
    r.record_changes = 3'(chg);
    r.batch_changes = 16'(total);
    r.entry_count = 6'(filled);
    r.batch_done = it.last;
    return r;
  endfunction

  task automatic send_item(input scan_item_t it, input logic typed,
                           input dtu_pkg::result_t typed_res);
    int               gap;
    dtu_pkg::result_t predicted;
    gap = (steady || burst) ? 0 : (($urandom_range(0, 2) == 0) ? pick_gap() : 0);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= it.func;
    in_ch.dev_addr <= it.addr;
    in_ch.rssi <= it.rssi;
    in_ch.tx_dbm <= it.tx_dbm;
    in_ch.adv_flags <= it.flags;
    in_ch.mfr_id <= it.company;
    in_ch.last_of_batch <= it.last;
    do @(posedge clk); while (!in_ch.ready);
    predicted = upsert_predict(it);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input dtu_pkg::cfg_idx_t idx, input logic [15:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      dtu_pkg::REG_TX_DBM_UNKNOWN: sentinels.tx_dbm_unknown = data[7:0];
      dtu_pkg::REG_FLAGS_NONE:     sentinels.flags_none = data[7:0];
      dtu_pkg::REG_COMPANY_NONE:   sentinels.company_none = data;
      default: ;
    endcase
  endtask

  task automatic program_sentinels(input logic [7:0] tx, input logic [7:0] fl,
                                   input logic [15:0] co, input bit poke_unused);
    write_reg(dtu_pkg::REG_TX_DBM_UNKNOWN, {8'($urandom), tx});
    write_reg(dtu_pkg::REG_FLAGS_NONE, {8'($urandom), fl});
    write_reg(dtu_pkg::REG_COMPANY_NONE, co);
    if (poke_unused) write_reg(REG_UNUSED, 16'($urandom));
    cfg_we <= 1'b0;
  endtask

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    dtu_pkg::result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no expectation pending");
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("entry_index", want.entry_index, out_ch.entry_index);
        check_field("hit", want.hit, out_ch.hit);
        check_field("inserted", want.inserted, out_ch.inserted);
        check_field("dropped_full", want.dropped_full, out_ch.dropped_full);
        check_field("record_changes", want.record_changes, out_ch.record_changes);
        check_field("batch_changes", want.batch_changes, out_ch.batch_changes);
        check_field("entry_count", want.entry_count, out_ch.entry_count);
        check_field("batch_done", want.batch_done, out_ch.batch_done);
      end
    end
  end

  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!steady && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  end

  initial begin
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("device_table_upsert_tb failed");
    $finish;
  end

  initial begin
    int phase;
    int k;
    int pool_size;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= dtu_pkg::REG_TX_DBM_UNKNOWN;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.func <= FUNC_MERGE;
    in_ch.dev_addr <= '0;
    in_ch.rssi <= '0;
    in_ch.tx_dbm <= '0;
    in_ch.adv_flags <= '0;
    in_ch.mfr_id <= '0;
    in_ch.last_of_batch <= 1'b0;
    filled = 0;
    batch_sum = 0;
    sentinels = '{8'sd127, 8'd0, 16'hFFFF};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < DIR_ROWS; k++) begin
      send_item(DIRECTED[k].item, DIRECTED[k].typed, DIRECTED[k].res);
    end

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase > 0) begin
        drain();
        if (phase % 3 == 1) program_sentinels(8'h80, 8'hFF, 16'h0000, phase == 4);
        else if (phase % 3 == 2) program_sentinels(8'h7F, 8'h00, 16'hFFFF, 1'b0);
        else program_sentinels(8'($urandom), 8'($urandom), 16'($urandom), 1'b0);
      end
      addr_pool.delete();
      pool_size = (phase % 2 == 1) ? $urandom_range(33, 56) : $urandom_range(1, 32);
      for (k = 0; k < pool_size; k++) addr_pool.push_back({16'($urandom), 32'($urandom)});
      steady = (phase % 4 == 3);
      burst = (phase == 2);
      if (burst) hold_req = 1'b1;
      for (k = 0; k < PHASE_ITEMS; k++) send_item(random_item(), 1'b0, '0);
    end

    drain();

    if (errors == 0) begin
      $display("device_table_upsert_tb passed");
    end else begin
      $display("device_table_upsert_tb failed");
    end
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/dtu_pkg.sv
hw/rtl/dtu_in_if.sv
hw/rtl/dtu_out_if.sv
hw/rtl/dtu_merge.sv
hw/rtl/device_table_upsert.sv
tb/device_table_upsert_tb.sv
